[rtl/world_point_to_pan_tilt_top_assert.svh]
// Assertion macros for the world point to pan/tilt top level.
`ifndef WORLD_POINT_TO_PAN_TILT_TOP_ASSERT_SVH
`define WORLD_POINT_TO_PAN_TILT_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante (needs clk and arst_n in scope).
`define WPT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wpt assertion failed");

// Check that cons holds in the cycle after ante.
`define WPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wpt assertion failed");

`endif

[rtl/wpt_pkg.sv]
// Package: types, constants and the angle table of the world point to pan/tilt block.
`timescale 1ns / 1ps
package wpt_pkg;

	localparam int CW           = 36;
	localparam int SQ_W         = 63;
	localparam int SQRT_STEPS   = 31;
	localparam int CORDIC_STEPS = 32;
	localparam int ATAN_STEPS   = 11;
	localparam int NUM_REGS     = 7;
	localparam int REG_IDX_W    = 3;

	localparam logic [REG_IDX_W-1:0] REG_ROW0_AB       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROW0_C_SHIFT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW1_AB       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROW1_C_SHIFT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROW2_AB       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROW2_C_SHIFT  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INV_HALF_FOV  = 3'd6;

	localparam logic [63:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0001_0000_0000, 64'h0, 64'h0000_0000_0100_0000, 64'h0,
		64'h0, 64'h0100_0000_0000_0000, 64'h0001_0001_0000_0000
	};

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_BEHIND = 2'd1;
	localparam logic [1:0] STATUS_SAT    = 2'd2;

	// leading one of the largest magnitude lands on this bit
	localparam logic [5:0] NORM_MSB = 6'd29;

	localparam logic signed [CW-1:0] ATAN_TBL [ATAN_STEPS] = '{
		36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
		36'sd268086748, 36'sd134174063, 36'sd67103403, 36'sd33553749,
		36'sd16777131, 36'sd8388597, 36'sd4194303
	};

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [31:0] norm_pan;
		logic signed [31:0] norm_tilt;
		logic [1:0]         status;
		logic               last_out;
	} result_t;

	typedef struct packed {
		logic [8:0][31:0] coef;
		logic [2:0][31:0] shift;
	} view_cfg_t;

	typedef struct packed {
		logic last;
		logic behind;
	} side_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [60:0]        sumsq;
		side_t              side;
	} norm_t;

	typedef struct packed {
		logic [SQ_W-1:0]    rem;
		logic [SQ_W-1:0]    root;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		side_t              side;
	} sqrt_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] ang;
	} vec_t;

	typedef struct packed {
		vec_t  pan;
		vec_t  tilt;
		side_t side;
	} cordic_t;

	// atan(2^-step) in Q.32; a plain power of two past the table
	function automatic logic signed [CW-1:0] atan_step(input int step);
		logic signed [CW-1:0] a;
		a = '0;
		if (step < ATAN_STEPS)
			a = ATAN_TBL[step];
		else
			a[32 - step] = 1'b1;
		return a;
	endfunction

endpackage

[rtl/wpt_front.sv]
// View transform, behind test, normalization and squares ahead of the root chain.
`timescale 1ns / 1ps
module wpt_front
	import wpt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  point_t    in_point,
	input  view_cfg_t cfg,
	output logic      out_valid,
	output norm_t     out_norm
);

	logic signed [31:0] w [3];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [63:0] view_s2 [3];
	logic [63:0]        mag_s3 [3];
	logic [63:0]        m_s3;
	logic               negx_s3, negy_s3;
	logic [7:0]         nz_s4;
	logic [2:0]         lead_s4 [8];
	logic [63:0]        mag_s4 [3];
	logic               negx_s4, negy_s4;
	logic [63:0]        mag_s5 [3];
	logic               negx_s5, negy_s5;
	logic               right_s5;
	logic [5:0]         amt_s5;
	logic signed [31:0] x_s6, y_s6, z_s6;
	logic [29:0]        ay_s6, az_s6;
	logic signed [31:0] x_s7, y_s7, z_s7;
	logic [59:0]        ysq_s7, zsq_s7;
	logic signed [31:0] x_s8, y_s8, z_s8;
	logic [60:0]        sumsq_s8;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [7:0]         valid_q;

	logic [7:0]  nz_c;
	logic [2:0]  lead_c [8];
	logic [5:0]  pos_c;
	logic        right_c;
	logic [29:0] sh_c [3];

	assign w[0] = in_point.world_x;
	assign w[1] = in_point.world_y;
	assign w[2] = in_point.world_z;

	// advance the valid bits of the eight stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[6:0], in_valid};
		end
	end

	// find the leading one of each byte of the largest magnitude
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			nz_c[j] = |m_s3[8*j +: 8];
			lead_c[j] = '0;
			for (int b = 0; b < 8; b++) begin
				if (m_s3[8*j + b]) lead_c[j] = 3'(b);
			end
		end
	end

	// combine byte results into the shift that puts the leading one on NORM_MSB
	always_comb begin
		pos_c = '0;
		for (int j = 0; j < 8; j++) begin
			if (nz_s4[j]) pos_c = {3'(j), lead_s4[j]};
		end
		right_c = (pos_c >= NORM_MSB);
	end

	// apply the common shift to the three magnitudes
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh_c[k] = right_s5 ? 30'(mag_s5[k] >> amt_s5) : 30'(mag_s5[k] << amt_s5);
		end
	end

	always_ff @(posedge clk) begin
		// products of coefficients and coordinates
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= $signed(cfg.coef[r*3 + c]) * w[c];
			end
		end
		side_s1 <= '{last: in_point.last_point, behind: 1'b0};

		// row sums plus translation
		for (int r = 0; r < 3; r++) begin
			view_s2[r] <= (prod_s1[r][0] >>> 8) + (prod_s1[r][1] >>> 8) + (prod_s1[r][2] >>> 8)
				+ $signed({{16{cfg.shift[r][31]}}, cfg.shift[r], 16'h0});
		end
		side_s2 <= side_s1;

		// magnitudes, signs, behind test and largest magnitude
		for (int k = 0; k < 3; k++) begin
			mag_s3[k] <= view_s2[k][63] ? 64'(-view_s2[k]) : 64'(view_s2[k]);
		end
		begin
			logic [63:0] ux, uy, uz, mxy;
			ux = view_s2[0][63] ? 64'(-view_s2[0]) : 64'(view_s2[0]);
			uy = view_s2[1][63] ? 64'(-view_s2[1]) : 64'(view_s2[1]);
			uz = view_s2[2][63] ? 64'(-view_s2[2]) : 64'(view_s2[2]);
			mxy = (ux > uy) ? ux : uy;
			m_s3 <= (uz > mxy) ? uz : mxy;
		end
		negx_s3 <= view_s2[0][63];
		negy_s3 <= view_s2[1][63];
		side_s3 <= '{last: side_s2.last, behind: view_s2[2][63] || (view_s2[2] == 64'sd0)};

		// per-byte leading one
		nz_s4   <= nz_c;
		lead_s4 <= lead_c;
		mag_s4  <= mag_s3;
		negx_s4 <= negx_s3;
		negy_s4 <= negy_s3;
		side_s4 <= side_s3;

		// shift direction and amount
		right_s5 <= right_c;
		amt_s5   <= right_c ? (pos_c - NORM_MSB) : (NORM_MSB - pos_c);
		mag_s5   <= mag_s4;
		negx_s5  <= negx_s4;
		negy_s5  <= negy_s4;
		side_s5  <= side_s4;

		// normalized values with signs restored
		x_s6  <= negx_s5 ? -$signed({2'b00, sh_c[0]}) : $signed({2'b00, sh_c[0]});
		y_s6  <= negy_s5 ? -$signed({2'b00, sh_c[1]}) : $signed({2'b00, sh_c[1]});
		z_s6  <= $signed({2'b00, sh_c[2]});
		ay_s6 <= sh_c[1];
		az_s6 <= sh_c[2];
		side_s6 <= side_s5;

		// squares for the root
		ysq_s7 <= ay_s6 * ay_s6;
		zsq_s7 <= az_s6 * az_s6;
		x_s7 <= x_s6;
		y_s7 <= y_s6;
		z_s7 <= z_s6;
		side_s7 <= side_s6;

		sumsq_s8 <= 61'(ysq_s7) + 61'(zsq_s7);
		x_s8 <= x_s7;
		y_s8 <= y_s7;
		z_s8 <= z_s7;
		side_s8 <= side_s7;
	end

	assign out_valid = valid_q[7];
	assign out_norm  = '{x: x_s8, y: y_s8, z: z_s8, sumsq: sumsq_s8, side: side_s8};

endmodule

[rtl/wpt_sqrt_cell.sv]
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
module wpt_sqrt_cell
	import wpt_pkg::*;
#(
	parameter int BIT_POS = 30
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  sqrt_t in_data,
	output logic  out_valid,
	output sqrt_t out_data
);

	localparam logic [SQ_W-1:0] DIGIT = SQ_W'(1) << (2 * BIT_POS);

	logic [SQ_W-1:0] trial;
	sqrt_t           nxt;
	logic            valid_q;
	sqrt_t           data_q;

	// try the next root digit against the remainder
	always_comb begin
		nxt   = in_data;
		trial = in_data.root + DIGIT;
		if (in_data.rem >= trial) begin
			nxt.rem  = in_data.rem - trial;
			nxt.root = (in_data.root >> 1) + DIGIT;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[rtl/wpt_cordic_cell.sv]
// One vectoring CORDIC step, applied to the pan and the tilt vector side by side.
`timescale 1ns / 1ps
module wpt_cordic_cell
	import wpt_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  cordic_t in_data,
	output logic    out_valid,
	output cordic_t out_data
);

	localparam logic signed [CW-1:0] ANG = atan_step(STEP);

	logic    valid_q;
	cordic_t data_q;

	// rotate toward the x axis and accumulate the angle
	function automatic vec_t rotate(input vec_t v);
		vec_t r;
		logic signed [CW-1:0] dx, dy;
		dx = $signed(v.y) >>> STEP;
		dy = $signed(v.x) >>> STEP;
		r  = v;
		if (!v.y[CW-1]) begin
			r.x   = v.x + dx;
			r.y   = v.y - dy;
			r.ang = v.ang + ANG;
		end else begin
			r.x   = v.x - dx;
			r.y   = v.y + dy;
			r.ang = v.ang - ANG;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q.pan  <= rotate(in_data.pan);
		data_q.tilt <= rotate(in_data.tilt);
		data_q.side <= in_data.side;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[rtl/wpt_scale.sv]
// Angle to normalized Q16.16: round to Q.30, multiply by the reciprocal, saturate.
`timescale 1ns / 1ps
module wpt_scale
	import wpt_pkg::*;
(
	input  logic                 clk,
	input  logic signed [CW-1:0] ang,
	input  logic [31:0]          inv,
	output logic [31:0]          value,
	output logic                 sat
);

	logic signed [CW-1:0] a_c;
	logic [32:0]          mag_s1;
	logic                 neg_s1;
	logic [64:0]          prod_s2;
	logic                 neg_s2;
	logic [34:0]          q_c;
	logic [31:0]          value_s3;
	logic                 sat_s3;

	assign a_c = (ang + CW'(2)) >>> 2;
	assign q_c = 35'((prod_s2 + (65'd1 << 29)) >> 30);

	always_ff @(posedge clk) begin
		// magnitude and sign of the Q.30 angle
		neg_s1 <= a_c[CW-1];
		mag_s1 <= a_c[CW-1] ? 33'(-a_c) : 33'(a_c);

		// scale by the reciprocal half field of view
		prod_s2 <= mag_s1 * inv;
		neg_s2  <= neg_s1;

		// round, restore sign and clamp
		if (neg_s2) begin
			if (q_c > 35'h0_8000_0000) begin
				sat_s3   <= 1'b1;
				value_s3 <= 32'h8000_0000;
			end else begin
				sat_s3   <= 1'b0;
				value_s3 <= -q_c[31:0];
			end
		end else begin
			if (q_c > 35'h0_7FFF_FFFF) begin
				sat_s3   <= 1'b1;
				value_s3 <= 32'h7FFF_FFFF;
			end else begin
				sat_s3   <= 1'b0;
				value_s3 <= q_c[31:0];
			end
		end
	end

	assign value = value_s3;
	assign sat   = sat_s3;

endmodule

[rtl/world_point_to_pan_tilt_top.sv]
// Top level: world point to normalized galvo pan/tilt, fully pipelined.
//
// A request is one world point (Q16.16 x, y, z and a last marker) on point,
// taken at a rising edge with start high and busy low. busy never rises: a
// new point may be given in every cycle, and up to 75 points are in flight.
// Each point yields one result on result, marked by done for one cycle; the
// receiver cannot hold results off and none is buffered.
// Path: a request passes through 8 front stages (transform, normalize,
// squares), 31 square root digit cells, 32 CORDIC cells, 3 scaling stages
// and the output register, which drives done.
// Throughput: one point per clock.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Indexes beyond the register list are ignored. Write only
// while no point is in flight.
// Reset (arst_n low) empties the pipeline and restores every configuration
// register to its reset value.
`timescale 1ns / 1ps
`include "world_point_to_pan_tilt_top_assert.svh"
module world_point_to_pan_tilt_top
	import wpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  point_t               point,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int LATENCY = 75;

	logic [63:0] cfg_q [NUM_REGS];
	view_cfg_t   view_cfg;

	logic    front_valid;
	norm_t   front_norm;
	logic    sq_valid [SQRT_STEPS+1];
	sqrt_t   sq_data [SQRT_STEPS+1];
	logic    cd_valid [CORDIC_STEPS+1];
	cordic_t cd_data [CORDIC_STEPS+1];

	logic [31:0] pan_val, tilt_val;
	logic        pan_sat, tilt_sat;
	logic        tail_valid_s1, tail_valid_s2, tail_valid_s3;
	side_t       tail_side_s1, tail_side_s2, tail_side_s3;
	logic        done_q;
	result_t     result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= REG_RESET[i];
		end else if (cfg_valid && cfg_ready && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// unpack coefficient pairs into the view transform
	always_comb begin
		view_cfg.coef[0]  = cfg_q[REG_ROW0_AB][63:32];
		view_cfg.coef[1]  = cfg_q[REG_ROW0_AB][31:0];
		view_cfg.coef[2]  = cfg_q[REG_ROW0_C_SHIFT][63:32];
		view_cfg.coef[3]  = cfg_q[REG_ROW1_AB][63:32];
		view_cfg.coef[4]  = cfg_q[REG_ROW1_AB][31:0];
		view_cfg.coef[5]  = cfg_q[REG_ROW1_C_SHIFT][63:32];
		view_cfg.coef[6]  = cfg_q[REG_ROW2_AB][63:32];
		view_cfg.coef[7]  = cfg_q[REG_ROW2_AB][31:0];
		view_cfg.coef[8]  = cfg_q[REG_ROW2_C_SHIFT][63:32];
		view_cfg.shift[0] = cfg_q[REG_ROW0_C_SHIFT][31:0];
		view_cfg.shift[1] = cfg_q[REG_ROW1_C_SHIFT][31:0];
		view_cfg.shift[2] = cfg_q[REG_ROW2_C_SHIFT][31:0];
	end

	wpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_point  (point),
		.cfg       (view_cfg),
		.out_valid (front_valid),
		.out_norm  (front_norm)
	);

	// seed the square root chain with the sum of squares
	assign sq_valid[0] = front_valid;
	assign sq_data[0]  = '{rem: SQ_W'(front_norm.sumsq), root: '0, x: front_norm.x,
		y: front_norm.y, z: front_norm.z, side: front_norm.side};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		wpt_sqrt_cell #(.BIT_POS(SQRT_STEPS - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_valid[i]),
			.in_data   (sq_data[i]),
			.out_valid (sq_valid[i+1]),
			.out_data  (sq_data[i+1])
		);
	end

	// pan vector is (r, X), tilt vector is (Z, Y)
	assign cd_valid[0] = sq_valid[SQRT_STEPS];
	assign cd_data[0]  = '{
		pan:  '{x: CW'(sq_data[SQRT_STEPS].root[30:0]), y: CW'(sq_data[SQRT_STEPS].x),
			ang: '0},
		tilt: '{x: CW'(sq_data[SQRT_STEPS].z), y: CW'(sq_data[SQRT_STEPS].y), ang: '0},
		side: sq_data[SQRT_STEPS].side
	};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		wpt_cordic_cell #(.STEP(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cd_valid[i]),
			.in_data   (cd_data[i]),
			.out_valid (cd_valid[i+1]),
			.out_data  (cd_data[i+1])
		);
	end

	wpt_scale u_scale_pan (
		.clk   (clk),
		.ang   (cd_data[CORDIC_STEPS].pan.ang),
		.inv   (cfg_q[REG_INV_HALF_FOV][63:32]),
		.value (pan_val),
		.sat   (pan_sat)
	);

	wpt_scale u_scale_tilt (
		.clk   (clk),
		.ang   (cd_data[CORDIC_STEPS].tilt.ang),
		.inv   (cfg_q[REG_INV_HALF_FOV][31:0]),
		.value (tilt_val),
		.sat   (tilt_sat)
	);

	// track valid alongside the scaling stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_s1 <= 1'b0;
			tail_valid_s2 <= 1'b0;
			tail_valid_s3 <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			tail_valid_s1 <= cd_valid[CORDIC_STEPS];
			tail_valid_s2 <= tail_valid_s1;
			tail_valid_s3 <= tail_valid_s2;
			done_q        <= tail_valid_s3;
		end
	end

	// drop angles of points behind the projector; merge saturation flags
	always_ff @(posedge clk) begin
		tail_side_s1 <= cd_data[CORDIC_STEPS].side;
		tail_side_s2 <= tail_side_s1;
		tail_side_s3 <= tail_side_s2;
		result_q.last_out <= tail_side_s3.last;
		if (tail_side_s3.behind) begin
			result_q.norm_pan  <= '0;
			result_q.norm_tilt <= '0;
			result_q.status    <= STATUS_BEHIND;
		end else begin
			result_q.norm_pan  <= pan_val;
			result_q.norm_tilt <= tilt_val;
			result_q.status    <= (pan_sat || tilt_sat) ? STATUS_SAT : STATUS_OK;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`WPT_ASSERT_IMP(a_done_latency, done, $past(start, LATENCY))
	`WPT_ASSERT_IMP(a_behind_zero, done && (result.status == STATUS_BEHIND),
		(result.norm_pan == 32'sd0) && (result.norm_tilt == 32'sd0))
	`WPT_ASSERT_IMP(a_status_code, done, (result.status == STATUS_OK) ||
		(result.status == STATUS_BEHIND) || (result.status == STATUS_SAT))
	`WPT_ASSERT_IMP(a_sat_bound, done && (result.status == STATUS_SAT),
		(result.norm_pan == 32'sh7FFF_FFFF) || (result.norm_pan == 32'sh8000_0000) ||
		(result.norm_tilt == 32'sh7FFF_FFFF) || (result.norm_tilt == 32'sh8000_0000))

endmodule

[bench/world_point_to_pan_tilt_top_tb.sv]
// Testbench for the world point to normalized pan/tilt block.
`timescale 1ns / 1ps
module world_point_to_pan_tilt_top_tb;
	import wpt_pkg::*;

	localparam int LATENCY_WAIT = 90;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	point_t               point = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;

	logic [63:0] view_regs [NUM_REGS];
	point_t      point_queue [$];
	result_t     angle_queue [$];
	int          mismatch_count = 0;
	bit          hold_points = 1'b0;
	int          burst_left = 0;
	int          gap_left = 0;

	world_point_to_pan_tilt_top dut (.*);

	always #5 clk = ~clk;

	// atan(2^-i) in Q.32, from a table for the first steps and a power of two past it
	function automatic longint atan_q32(int i);
		longint tbl [11] = '{64'sd3373259426, 64'sd1991351318, 64'sd1052175346,
			64'sd534100635, 64'sd268086748, 64'sd134174063, 64'sd67103403,
			64'sd33553749, 64'sd16777131, 64'sd8388597, 64'sd4194303};
		if (i <= 10)
			return tbl[i];
		return longint'(1) <<< (32 - i);
	endfunction

	function automatic longint view_coord(int r, longint x, longint y, longint z);
		logic [63:0] ab;
		logic [63:0] cs;
		longint      s;
		ab = view_regs[2 * r];
		cs = view_regs[2 * r + 1];
		s = (longint'($signed(ab[63:32])) * x) >>> 8;
		s += (longint'($signed(ab[31:0])) * y) >>> 8;
		s += (longint'($signed(cs[63:32])) * z) >>> 8;
		s += longint'($signed(cs[31:0])) * 65536;
		return s;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// vectoring rotation: angle of (x, y) in Q.32
	function automatic longint vector_angle(longint x, longint y);
		longint ang;
		longint dx;
		longint dy;
		ang = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; ang += atan_q32(i);
			end else begin
				x -= dx; y += dy; ang -= atan_q32(i);
			end
		end
		return ang;
	endfunction

	function automatic logic [31:0] fov_scale(longint ang, logic [31:0] inv, inout bit sat);
		longint      a;
		logic [63:0] q;
		a = (ang + 2) >>> 2;
		q = ((a < 0 ? 64'(-a) : 64'(a)) * {32'd0, inv} + (64'd1 << 29)) >> 30;
		if (a < 0) begin
			if (q > 64'h8000_0000) begin
				sat = 1'b1;
				q = 64'h8000_0000;
			end
			return 32'(64'd0 - q);
		end
		if (q > 64'h7FFF_FFFF) begin
			sat = 1'b1;
			q = 64'h7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	function automatic result_t predict_angles(point_t p);
		result_t     r;
		longint      vx, vy, vz;
		logic [63:0] ux, uy, uz, m;
		longint      sx, sy, sz, rad;
		bit          sat;
		sat = 1'b0;
		r = '0;
		r.last_out = p.last_point;
		vx = view_coord(0, p.world_x, p.world_y, p.world_z);
		vy = view_coord(1, p.world_x, p.world_y, p.world_z);
		vz = view_coord(2, p.world_x, p.world_y, p.world_z);
		if (vz <= 0) begin
			r.status = STATUS_BEHIND;
			return r;
		end
		ux = vx < 0 ? 64'(-vx) : 64'(vx);
		uy = vy < 0 ? 64'(-vy) : 64'(vy);
		uz = 64'(vz);
		m = ux > uy ? ux : uy;
		if (uz > m)
			m = uz;
		// bring the largest magnitude into [2^29, 2^30)
		while (m >= (64'd1 << 30)) begin
			m >>= 1; ux >>= 1; uy >>= 1; uz >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			m <<= 1; ux <<= 1; uy <<= 1; uz <<= 1;
		end
		sx = vx < 0 ? -longint'(ux) : longint'(ux);
		sy = vy < 0 ? -longint'(uy) : longint'(uy);
		sz = longint'(uz);
		rad = longint'(root_floor(uy * uy + uz * uz));
		r.norm_pan = fov_scale(vector_angle(rad, sx), view_regs[REG_INV_HALF_FOV][63:32], sat);
		r.norm_tilt = fov_scale(vector_angle(sz, sy), view_regs[REG_INV_HALF_FOV][31:0], sat);
		r.status = sat ? STATUS_SAT : STATUS_OK;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s at %0t: got %h expected %h", what, $time, got, want);
		mismatch_count++;
	endtask

	// Driver: present queued points in bursts, predict each accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				angle_queue = {angle_queue, predict_angles(point_queue.pop_front())};
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (point_queue.size() == 0 || hold_points) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				point <= point_queue[0];
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor: check each result against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (angle_queue.size() == 0) begin
				report_mismatch("unexpected result", result[31:0], '0);
			end else begin
				want = angle_queue.pop_front();
				if (result.norm_pan !== want.norm_pan)
					report_mismatch("norm_pan", result.norm_pan, want.norm_pan);
				if (result.norm_tilt !== want.norm_tilt)
					report_mismatch("norm_tilt", result.norm_tilt, want.norm_tilt);
				if (result.status !== want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.last_out !== want.last_out)
					report_mismatch("last_out", 32'(result.last_out), 32'(want.last_out));
			end
		end
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS)
			view_regs[idx] = data;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (point_queue.size() != 0 || angle_queue.size() != 0 || start)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			4: return 32'h1;
			default: return $urandom;
		endcase
	endfunction

	function automatic point_t random_point();
		point_t p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				// point in front at a plausible range
				p.world_x = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
				p.world_y = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
				p.world_z = $urandom_range(1, 1 << 28);
			end
			6, 7: begin
				p.world_x = $urandom;
				p.world_y = $urandom;
				p.world_z = $urandom;
			end
			8: begin
				p.world_x = $signed($urandom_range(0, 8)) - 4;
				p.world_y = $signed($urandom_range(0, 8)) - 4;
				p.world_z = $signed($urandom_range(0, 8)) - 4;
			end
			default: begin
				p.world_x = edge_word();
				p.world_y = edge_word();
				p.world_z = edge_word();
			end
		endcase
		p.last_point = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	function automatic logic [31:0] small_coef();
		return $urandom_range(0, 1 << 26) - (1 << 25);
	endfunction

	task automatic queue_random(int n);
		repeat (n) point_queue = {point_queue, random_point()};
	endtask

	initial begin
		point_t p;
		for (int i = 0; i < NUM_REGS; i++)
			view_regs[i] = REG_RESET[i];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero and negative depth, marker, under reset view
		p = '0;
		point_queue = {point_queue, p};
		p.world_z = 32'sd1;
		point_queue = {point_queue, p};
		p.world_z = -32'sd1;
		point_queue = {point_queue, p};
		p.world_z = 32'sh7FFF_FFFF;
		point_queue = {point_queue, p};
		p.world_z = 32'sh8000_0000;
		point_queue = {point_queue, p};
		p.last_point = 1'b1;
		p.world_x = 32'sh7FFF_FFFF; p.world_y = 32'sh8000_0000; p.world_z = 32'sh10000;
		point_queue = {point_queue, p};
		p.last_point = 1'b0;
		p.world_x = 32'sh8000_0000; p.world_y = 32'sh7FFF_FFFF; p.world_z = 32'sh7FFF_FFFF;
		point_queue = {point_queue, p};
		p.world_x = 32'sh8000_0000; p.world_y = 32'sh8000_0000; p.world_z = 32'sh1;
		point_queue = {point_queue, p};
		p.world_x = 32'sh1_0000; p.world_y = 32'sh1_0000; p.world_z = 32'sh0;
		point_queue = {point_queue, p};
		p.world_x = -32'sh1_0000; p.world_y = -32'sh1_0000; p.world_z = 32'sh1_0000;
		point_queue = {point_queue, p};
		p.world_x = 32'sh7FFF_FFFF; p.world_y = 32'sh7FFF_FFFF; p.world_z = 32'sh7FFF_FFFF;
		p.last_point = 1'b1;
		point_queue = {point_queue, p};
		queue_random(170);

		// Stall the sender until everything in flight has come back
		wait (point_queue.size() < 60);
		hold_points = 1'b1;
		while (angle_queue.size() != 0 || start)
			@(posedge clk);
		hold_points = 1'b0;
		drain();

		// Near identity view with offsets and random field of view
		write_reg(REG_ROW0_AB, {32'h0100_0000, $signed(small_coef()) >>> 4});
		write_reg(REG_ROW0_C_SHIFT, {$signed(small_coef()) >>> 4,
			32'($urandom_range(0, 1 << 20))});
		write_reg(REG_ROW1_AB, {$signed(small_coef()) >>> 4, 32'h0100_0000});
		write_reg(REG_ROW1_C_SHIFT, {$signed(small_coef()) >>> 4,
			32'($urandom_range(0, 1 << 20))});
		write_reg(REG_ROW2_AB, {$signed(small_coef()) >>> 4, $signed(small_coef()) >>> 4});
		write_reg(REG_ROW2_C_SHIFT, {32'h0100_0000, 32'($urandom_range(0, 1 << 18))});
		write_reg(REG_INV_HALF_FOV, {32'($urandom_range(1 << 15, 1 << 19)),
			32'($urandom_range(1 << 15, 1 << 19))});
		queue_random(190);
		drain();

		// Arbitrary rotation-like view
		for (int i = 0; i < REG_INV_HALF_FOV; i++)
			write_reg(REG_IDX_W'(i), {small_coef(), small_coef()});
		write_reg(REG_INV_HALF_FOV, {32'($urandom), 32'($urandom_range(0, 1 << 20))});
		queue_random(190);
		drain();

		// Fully random registers
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(REG_IDX_W'(i), {$urandom, $urandom});
		queue_random(180);
		drain();

		// All ones everywhere, largest reciprocals
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(REG_IDX_W'(i), '1);
		queue_random(170);
		drain();

		// Largest positive coefficients and offsets, most negative row 2 x and y coefficients
		for (int i = 0; i < REG_INV_HALF_FOV; i++)
			write_reg(REG_IDX_W'(i), 64'h7FFF_FFFF_7FFF_FFFF);
		write_reg(REG_ROW2_AB, 64'h8000_0000_8000_0000);
		write_reg(REG_INV_HALF_FOV, 64'hFFFF_FFFF_0000_0000);
		queue_random(170);
		drain();

		// Back to reset values; an index past the list must be ignored
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(REG_IDX_W'(i), REG_RESET[i]);
		write_reg(3'd7, '1);
		queue_random(180);
		drain();

		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/wpt_pkg.sv
rtl/wpt_front.sv
rtl/wpt_sqrt_cell.sv
rtl/wpt_cordic_cell.sv
rtl/wpt_scale.sv
rtl/world_point_to_pan_tilt_top.sv
bench/world_point_to_pan_tilt_top_tb.sv
